### sv/dim_pkg.sv
// Shared types, codes and constants for the LED dimmer effect engine.
package dim_pkg;

  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  // Event codes as they arrive on the input stream
  localparam logic [2:0] ActTick     = 3'd0;
  localparam logic [2:0] ActSetLevel = 3'd1;
  localparam logic [2:0] ActStart    = 3'd2;
  localparam logic [2:0] ActLoad     = 3'd3;
  localparam logic [2:0] ActClear    = 3'd4;

  // Effect codes
  localparam logic [2:0] EffNone     = 3'd0;
  localparam logic [2:0] EffFade     = 3'd1;
  localparam logic [2:0] EffStrobe   = 3'd2;
  localparam logic [2:0] EffSequence = 3'd3;
  localparam logic [2:0] EffFlicker  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CfgEnable    = 2'd0;
  localparam logic [1:0] CfgBipolar   = 2'd1;
  localparam logic [1:0] CfgInverse   = 2'd2;
  localparam logic [1:0] CfgDriveMode = 2'd3;

  localparam logic [1:0] DriveExtEffects = 2'd2;

  localparam int unsigned NumParams = 5;
  localparam logic [2:0]  ParamLimit = 3'd5;

  localparam logic [7:0] LevelFull      = 8'd255;
  localparam logic [7:0] BipolarThresh  = 8'd127;

  typedef enum logic [2:0] {
    OpNop,
    OpTick,
    OpSetLevel,
    OpStart,
    OpLoad,
    OpClear
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       refresh;
    logic [7:0] value;     // level for set level, data for parameter load
    logic [2:0] kind;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       enabled;
    logic       bipolar;
    logic       inverse;
    logic [1:0] drive_mode;
  } cfg_t;

  // Packed so that drive_level lands in the lowest bits
  typedef struct packed {
    logic       drive_updated;
    logic       start_next;
    logic [2:0] active_effect;
    logic [7:0] logical_level;
    logic [7:0] drive_level;
  } res_t;

endpackage

### sv/dim_front.sv
// Input side: takes event beats and classifies them into commands.
module dim_front import dim_pkg::*; (
  input  cfg_t                 cfg_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,
  input  logic                 q_full_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  logic [2:0] action;
  logic       refresh;
  logic [7:0] level;
  logic [2:0] kind;
  logic [2:0] idx;
  logic [7:0] value;
  logic       ext_fx;

  assign action  = s_axis_tdata[2:0];
  assign refresh = s_axis_tdata[3];
  assign level   = s_axis_tdata[11:4];
  assign kind    = s_axis_tdata[14:12];
  assign idx     = s_axis_tdata[17:15];
  assign value   = s_axis_tdata[25:18];

  assign ext_fx  = (cfg_i.drive_mode == DriveExtEffects);

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  always_comb begin
    cmd_o.op      = OpNop;
    cmd_o.refresh = refresh;
    cmd_o.value   = value;
    cmd_o.kind    = kind;
    cmd_o.idx     = idx;
    if (cfg_i.enabled) begin
      case (action)
        ActTick: begin
          if (!ext_fx) cmd_o.op = OpTick;
        end
        ActSetLevel: begin
          cmd_o.op    = OpSetLevel;
          cmd_o.value = level;
        end
        ActStart: begin
          if (!ext_fx && kind <= EffFlicker) cmd_o.op = OpStart;
        end
        ActLoad: begin
          if (!ext_fx && idx < ParamLimit) cmd_o.op = OpLoad;
        end
        ActClear: begin
          cmd_o.op = OpClear;
        end
        default: begin
          cmd_o.op = OpNop;
        end
      endcase
    end
  end

endmodule

### sv/dim_queue.sv
// Short command queue between the classifier and the effect sequencer.
module dim_queue import dim_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

endmodule

### sv/dim_back.sv
// Effect sequencer: runs commands against the channel state, registers results.
module dim_back import dim_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 cmd_valid_i,
  input  cmd_t                 cmd_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata
);

  logic [7:0] lvl_q, lvl_d;
  logic [2:0] eff_q, eff_d;
  logic [7:0] p_q [NumParams];
  logic [7:0] p_d [NumParams];
  logic       wr;
  logic       nxt;

  logic       fade_up;
  logic [7:0] fade_diff;
  logic [7:0] strb_dec;
  logic [7:0] seq_on_time;
  logic [7:0] flk_saved;

  logic       out_valid_q;
  res_t       out_q;
  res_t       res;

  function automatic logic [7:0] map_drive(input logic [7:0] v, input cfg_t c);
    logic [7:0] d;
    d = v;
    if (c.bipolar) d = (d > BipolarThresh) ? LevelFull : 8'd0;
    if (c.inverse) d = LevelFull - d;
    return d;
  endfunction

  assign pop_o = cmd_valid_i && (!out_valid_q || m_axis_tready);

  assign fade_up     = (p_q[0] > lvl_q);
  assign fade_diff   = fade_up ? (p_q[0] - lvl_q) : (lvl_q - p_q[0]);
  assign strb_dec    = p_q[4] - 1'b1;
  assign seq_on_time = (p_q[4] == 8'd0) ? p_q[2] : p_q[4];
  assign flk_saved   = (p_q[3] == 8'd0) ? lvl_q : p_q[2];

  always_comb begin
    lvl_d = lvl_q;
    eff_d = eff_q;
    p_d   = p_q;
    wr    = 1'b0;
    nxt   = 1'b0;
    case (cmd_i.op)
      OpTick: begin
        // ticks only reach here outside external effects mode, so writes hit the drive
        case (eff_q)
          EffNone: begin
            wr = cmd_i.refresh;
          end
          EffFade: begin
            if (p_q[2] == p_q[3]) begin
              p_d[3] = 8'd0;
              wr     = 1'b1;
              if (fade_diff < p_q[1]) begin
                lvl_d  = p_q[0];
                eff_d  = EffNone;
                p_d[0] = 8'd0;
                p_d[1] = 8'd0;
                p_d[2] = 8'd0;
              end else if (fade_up) begin
                lvl_d = lvl_q + p_q[1];
              end else begin
                lvl_d = lvl_q - p_q[1];
              end
            end else begin
              p_d[3] = p_q[3] + 1'b1;
            end
          end
          EffStrobe: begin
            if (p_q[4] == 8'd0) begin
              lvl_d  = p_q[2];
              wr     = 1'b1;
              p_d[4] = p_q[0];
            end else if (lvl_q == p_q[2]) begin
              p_d[4] = strb_dec;
              if (strb_dec == 8'd0) begin
                lvl_d  = p_q[3];
                wr     = 1'b1;
                p_d[4] = p_q[1];
              end
            end else if (lvl_q == p_q[3]) begin
              p_d[4] = strb_dec;
              if (strb_dec == 8'd0) begin
                lvl_d  = p_q[2];
                wr     = 1'b1;
                p_d[4] = p_q[0];
              end
            end else begin
              // level moved from outside: restart the count
              p_d[4] = 8'd0;
            end
          end
          EffSequence: begin
            p_d[4] = seq_on_time;
            if (lvl_q != p_q[0]) begin
              lvl_d = p_q[0];
              wr    = 1'b1;
            end
            if (p_q[2] == 8'd0) begin
              p_d[2] = seq_on_time;
              lvl_d  = p_q[1];
              wr     = 1'b1;
              eff_d  = EffNone;
              nxt    = (p_q[3] != 8'd0);
            end else begin
              p_d[2] = p_q[2] - 1'b1;
            end
          end
          EffFlicker: begin
            p_d[2] = flk_saved;
            p_d[3] = (p_q[3] == 8'd0) ? 8'd1 : p_q[3];
            if (lvl_q != p_q[0]) begin
              lvl_d = p_q[0];
              wr    = 1'b1;
            end
            if (p_q[1] == 8'd0) begin
              lvl_d = flk_saved;
              wr    = 1'b1;
              eff_d = EffNone;
            end else begin
              p_d[1] = p_q[1] - 1'b1;
            end
          end
          default: begin
            wr = 1'b0;
          end
        endcase
      end
      OpSetLevel: begin
        lvl_d = cmd_i.value;
        wr    = (cfg_i.drive_mode != DriveExtEffects);
      end
      OpStart: begin
        eff_d = cmd_i.kind;
      end
      OpLoad: begin
        p_d[cmd_i.idx] = cmd_i.value;
      end
      OpClear: begin
        eff_d = EffNone;
        for (int i = 0; i < NumParams; i++) p_d[i] = 8'd0;
      end
      default: begin
        lvl_d = lvl_q;
      end
    endcase
  end

  always_comb begin
    res.drive_level   = map_drive(lvl_d, cfg_i);
    res.logical_level = lvl_d;
    res.active_effect = eff_d;
    res.start_next    = nxt;
    res.drive_updated = wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q       <= 8'd0;
      eff_q       <= EffNone;
      for (int i = 0; i < NumParams; i++) p_q[i] <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        lvl_q <= lvl_d;
        eff_q <= eff_d;
        p_q   <= p_d;
      end
      if (pop_o) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(res_t)){1'b0}}, out_q};

  a_next_ends_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.start_next |->
      out_q.drive_updated && (out_q.active_effect == EffNone))
    else $error("start_next without a finished sequence");

  a_eff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eff_q <= EffFlicker)
    else $error("effect register out of range");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && (out_q.logical_level == lvl_q) &&
              (out_q.active_effect == eff_q))
    else $error("result register does not match channel state");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(lvl_q) && $stable(eff_q))
    else $error("channel state changed without a command");

endmodule

### sv/led_dimmer_effect_engine.sv
// Top level of the LED dimmer effect engine: config registers, front, queue, back.
//
// Usage:
//   Events arrive as beats on s_axis (tdata: action[2:0], refresh[3], level[11:4],
//   effect_kind[14:12], param_index[17:15], param_value[25:18]). Each event gives
//   exactly one result beat on m_axis (tdata: drive_level[7:0],
//   logical_level[15:8], active_effect[18:16], start_next[19], drive_updated[20]).
//   Configuration registers (0 enable, 1 bipolar, 2 inverse, 3 drive mode) are
//   written through cfg_valid_i/cfg_index_i/cfg_data_i, always ready; write them
//   only while no event is in flight.
//   Path: an event is held in the command queue, then its result is registered
//   in the sequencer's result register before it appears on m_axis.
//   Throughput: one event per cycle while m_axis_tready is high; the sequencer
//   updates the channel state on each pop, so the output register sets the pace.
//   Reset clears configuration, level, effect and all effect parameters, and
//   empties the queue. When the receiver stalls the result register holds,
//   the queue fills, and s_axis_tready drops once QueueDepth events wait.
module led_dimmer_effect_engine import dim_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [1:0]           cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // action, refresh, level, effect_kind, param_index, param_value (from bit 0)
  input  logic [InDataW-1:0]   s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // drive_level, logical_level, active_effect, start_next, drive_updated (from bit 0)
  output logic [OutDataW-1:0]  m_axis_tdata
);

  cfg_t cfg_q, cfg_d;
  cmd_t front_cmd;
  cmd_t q_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_valid;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgEnable:    cfg_d.enabled    = cfg_data_i[0];
        CfgBipolar:   cfg_d.bipolar    = cfg_data_i[0];
        CfgInverse:   cfg_d.inverse    = cfg_data_i[0];
        CfgDriveMode: cfg_d.drive_mode = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dim_front u_front (
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  dim_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  dim_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### dv/tb.sv
// Self-checking stream testbench for the LED dimmer effect engine.
`timescale 1ns / 1ps

module tb;
  import dim_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  // Codes with no name in the package: out-of-range actions, kinds and slots
  localparam logic [2:0] ActUnknown     = 3'd5;
  localparam logic [2:0] ActUnknownTop  = 3'd7;
  localparam logic [2:0] EffUnknown     = 3'd5;
  localparam logic [2:0] EffUnknownTop  = 3'd7;
  localparam logic [2:0] SlotBeyond     = 3'd5;
  localparam logic [2:0] SlotBeyondTop  = 3'd7;

  // Parameter slots as the fade and strobe effects use them
  localparam logic [2:0] SlotFadeTarget = 3'd0;
  localparam logic [2:0] SlotFadeStep   = 3'd1;
  localparam logic [2:0] SlotFadeSkip   = 3'd2;
  localparam logic [2:0] SlotFadeCount  = 3'd3;
  localparam logic [2:0] SlotStrobeUpT  = 3'd0;
  localparam logic [2:0] SlotStrobeUpV  = 3'd2;

  typedef struct {
    logic [2:0] action;
    logic       refresh;
    logic [7:0] level;
    logic [2:0] kind;
    logic [2:0] idx;
    logic [7:0] val;
  } event_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = '0;
  logic [1:0]          cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  led_dimmer_effect_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Channel state as the testbench tracks it
  logic       ch_enabled = 1'b0;
  logic       ch_bipolar = 1'b0;
  logic       ch_inverse = 1'b0;
  logic [1:0] ch_drive_mode = '0;
  logic [7:0] ch_level = '0;
  logic [2:0] ch_effect = EffNone;
  logic [7:0] ch_param [NumParams] = '{default: '0};
  logic       drive_written;
  logic       next_started;

  event_t event_q [$];
  res_t   dimmer_out_q [$];
  event_t offer;
  bit     offer_taken = 1'b0;
  int     n_pushed = 0;
  int     n_fail = 0;
  int     snd_idle_pct = 0;
  int     rcv_idle_pct = 0;
  int     rx_hold_left = 0;
  int     stall_cycles = 0;

  function automatic void write_level(logic [7:0] v);
    ch_level = v;
    if (ch_drive_mode != DriveExtEffects) drive_written = 1'b1;
  endfunction

  function automatic void advance_effect(logic refresh);
    int diff;
    case (ch_effect)
      EffNone: begin
        if (refresh) write_level(ch_level);
      end
      EffFade: begin
        if (ch_param[2] == ch_param[3]) begin
          ch_param[3] = '0;
          diff = (ch_param[0] > ch_level) ? ch_param[0] - ch_level : ch_level - ch_param[0];
          if (diff < ch_param[1]) begin
            write_level(ch_param[0]);
            ch_effect = EffNone;
            ch_param[0] = '0;
            ch_param[1] = '0;
            ch_param[2] = '0;
          end else if (ch_param[0] > ch_level) begin
            write_level(ch_level + ch_param[1]);
          end else begin
            write_level(ch_level - ch_param[1]);
          end
        end else begin
          ch_param[3] = ch_param[3] + 8'd1;
        end
      end
      EffStrobe: begin
        if (ch_param[4] == '0) begin
          write_level(ch_param[2]);
          ch_param[4] = ch_param[0];
        end else if (ch_level == ch_param[2]) begin
          ch_param[4] = ch_param[4] - 8'd1;
          if (ch_param[4] == '0) begin
            write_level(ch_param[3]);
            ch_param[4] = ch_param[1];
          end
        end else if (ch_level == ch_param[3]) begin
          ch_param[4] = ch_param[4] - 8'd1;
          if (ch_param[4] == '0) begin
            write_level(ch_param[2]);
            ch_param[4] = ch_param[0];
          end
        end else begin
          // level moved from outside: restart the count
          ch_param[4] = '0;
        end
      end
      EffSequence: begin
        if (ch_param[4] == '0) ch_param[4] = ch_param[2];
        if (ch_level != ch_param[0]) write_level(ch_param[0]);
        if (ch_param[2] == '0) begin
          ch_param[2] = ch_param[4];
          write_level(ch_param[1]);
          ch_effect = EffNone;
          if (ch_param[3] != '0) next_started = 1'b1;
        end else begin
          ch_param[2] = ch_param[2] - 8'd1;
        end
      end
      EffFlicker: begin
        if (ch_param[3] == '0) begin
          ch_param[2] = ch_level;
          ch_param[3] = 8'd1;
        end
        if (ch_level != ch_param[0]) write_level(ch_param[0]);
        if (ch_param[1] == '0) begin
          write_level(ch_param[2]);
          ch_effect = EffNone;
        end else begin
          ch_param[1] = ch_param[1] - 8'd1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic res_t predict_channel(event_t e);
    res_t       r;
    logic [7:0] d;
    drive_written = 1'b0;
    next_started  = 1'b0;
    if (ch_enabled) begin
      case (e.action)
        ActTick: begin
          if (ch_drive_mode != DriveExtEffects) advance_effect(e.refresh);
        end
        ActSetLevel: write_level(e.level);
        ActStart: begin
          if (ch_drive_mode != DriveExtEffects && e.kind <= EffFlicker) ch_effect = e.kind;
        end
        ActLoad: begin
          if (ch_drive_mode != DriveExtEffects && e.idx < ParamLimit) ch_param[e.idx] = e.val;
        end
        ActClear: begin
          ch_effect = EffNone;
          foreach (ch_param[i]) ch_param[i] = '0;
        end
        default: ;
      endcase
    end
    d = ch_level;
    if (ch_bipolar) d = (d > BipolarThresh) ? LevelFull : '0;
    if (ch_inverse) d = LevelFull - d;
    r.drive_level   = d;
    r.logical_level = ch_level;
    r.active_effect = ch_effect;
    r.start_next    = next_started;
    r.drive_updated = drive_written;
    return r;
  endfunction

  function automatic logic [InDataW-1:0] pack_event(event_t e);
    logic [InDataW-1:0] w;
    w = '0;
    w[2:0]   = e.action;
    w[3]     = e.refresh;
    w[11:4]  = e.level;
    w[14:12] = e.kind;
    w[17:15] = e.idx;
    w[25:18] = e.val;
    return w;
  endfunction

  function automatic void push_event(logic [2:0] action, logic refresh, logic [7:0] level,
                                     logic [2:0] kind, logic [2:0] idx, logic [7:0] val);
    event_t e;
    e.action  = action;
    e.refresh = refresh;
    e.level   = level;
    e.kind    = kind;
    e.idx     = idx;
    e.val     = val;
    event_q.push_back(e);
    n_pushed++;
  endfunction

  task automatic report_mismatch(string msg);
    if (n_fail < 40) $display("MISMATCH at %0t: %s", $time, msg);
    n_fail++;
  endtask

  // Input side: predict on the accepting edge, drive on the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      dimmer_out_q.push_back(predict_channel(offer));
      offer_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || offer_taken) begin
      offer_taken = 1'b0;
      if (event_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        offer = event_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_event(offer);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(res_t)-1:0];
      if (dimmer_out_q.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected, tdata %h", m_axis_tdata));
      end else begin
        want = dimmer_out_q.pop_front();
        if (got.drive_level != want.drive_level)
          report_mismatch($sformatf("drive_level %0d, expected %0d",
                                    got.drive_level, want.drive_level));
        if (got.logical_level != want.logical_level)
          report_mismatch($sformatf("logical_level %0d, expected %0d",
                                    got.logical_level, want.logical_level));
        if (got.active_effect != want.active_effect)
          report_mismatch($sformatf("active_effect %0d, expected %0d",
                                    got.active_effect, want.active_effect));
        if (got.start_next != want.start_next)
          report_mismatch($sformatf("start_next %0d, expected %0d",
                                    got.start_next, want.start_next));
        if (got.drive_updated != want.drive_updated)
          report_mismatch($sformatf("drive_updated %0d, expected %0d",
                                    got.drive_updated, want.drive_updated));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgEnable:    ch_enabled    = data[0];
      CfgBipolar:   ch_bipolar    = data[0];
      CfgInverse:   ch_inverse    = data[0];
      CfgDriveMode: ch_drive_mode = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every pushed event is taken and every result has come back
  task automatic drain();
    do @(posedge clk_i);
    while (event_q.size() != 0 || s_axis_tvalid || dimmer_out_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) push_event($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  // Load a plausible parameter set, start the effect, then mostly tick
  task automatic add_effect_run();
    logic [2:0] k;
    logic [7:0] v;
    int         r;
    int         nt;
    k = $urandom_range(EffFade, EffFlicker);
    if ($urandom_range(1) != 0)
      push_event(ActSetLevel, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    for (int s = 0; s < NumParams; s++) begin
      if ($urandom_range(99) < 85) begin
        v = $urandom();
        case (k)
          EffFade: begin
            case (s)
              1: v = ($urandom_range(9) == 0) ? '0 : 8'($urandom_range(1, 64));
              2: v = $urandom_range(3);
              3: if ($urandom_range(5) != 0) v = '0;
              default: ;
            endcase
          end
          EffStrobe: begin
            case (s)
              0, 1: v = $urandom_range(4);
              4: v = $urandom_range(2);
              default: ;
            endcase
          end
          EffSequence: begin
            case (s)
              2: v = $urandom_range(6);
              3: if ($urandom_range(1) != 0) v = '0;
              4: if ($urandom_range(2) != 0) v = '0;
              default: ;
            endcase
          end
          default: begin
            case (s)
              1: v = $urandom_range(6);
              3: if ($urandom_range(3) != 0) v = '0;
              default: ;
            endcase
          end
        endcase
        if ($urandom_range(19) == 0) v = $urandom();
        push_event(ActLoad, $urandom(), $urandom(), $urandom(), s, v);
      end
    end
    push_event(ActStart, $urandom(), $urandom(), k, $urandom(), $urandom());
    nt = $urandom_range(1, 24);
    repeat (nt) begin
      r = $urandom_range(99);
      if (r < 5)
        push_event(ActSetLevel, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      else if (r < 8)
        push_event(ActLoad, $urandom(), $urandom(), $urandom(),
                   $urandom_range(NumParams - 1), $urandom());
      else if (r < 10)
        push_event(ActClear, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      else
        push_event(ActTick, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    end
  endtask

  task automatic run_phase(logic en, logic bip, logic inv, logic [1:0] mode, int n,
                           int snd_pct, int rcv_pct, int hold);
    logic [1:0] d;
    int         target;
    d = {1'($urandom_range(1)), en};
    write_reg(CfgEnable, d);
    d = {1'($urandom_range(1)), bip};
    write_reg(CfgBipolar, d);
    d = {1'($urandom_range(1)), inv};
    write_reg(CfgInverse, d);
    write_reg(CfgDriveMode, mode);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    rx_hold_left = hold;
    target = n_pushed + n;
    while (n_pushed < target) begin
      if ($urandom_range(99) < 70) add_effect_run();
      else add_noise();
    end
    drain();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Channel disabled after reset: everything is ignored
    snd_idle_pct = 33;
    rcv_idle_pct = 47;
    push_event(ActSetLevel, 1'b0, LevelFull, EffNone, '0, '0);
    push_event(ActStart, 1'b0, '0, EffFade, '0, '0);
    push_event(ActTick, 1'b1, '0, EffNone, '0, '0);
    drain();

    write_reg(CfgEnable, 2'b01);
    push_event(ActSetLevel, 1'b0, LevelFull, EffNone, '0, '0);
    push_event(ActSetLevel, 1'b0, '0, EffNone, '0, '0);
    push_event(ActTick, 1'b1, '0, EffNone, '0, '0);
    push_event(ActTick, 1'b0, '0, EffNone, '0, '0);
    push_event(ActUnknownTop, 1'b1, LevelFull, EffFade, '0, LevelFull);
    push_event(ActStart, 1'b0, '0, EffUnknownTop, '0, '0);
    push_event(ActStart, 1'b0, '0, EffUnknown, '0, '0);
    push_event(ActLoad, 1'b0, '0, EffNone, SlotBeyondTop, LevelFull);
    // fade with a zero step keeps rewriting the level
    push_event(ActLoad, 1'b0, '0, EffNone, SlotFadeTarget, 8'd200);
    push_event(ActLoad, 1'b0, '0, EffNone, SlotFadeStep, '0);
    push_event(ActLoad, 1'b0, '0, EffNone, SlotFadeSkip, 8'd1);
    push_event(ActStart, 1'b0, '0, EffFade, '0, '0);
    push_event(ActTick, 1'b0, '0, EffNone, '0, '0);
    push_event(ActTick, 1'b0, '0, EffNone, '0, '0);
    // skip counter past the skip value counts up
    push_event(ActLoad, 1'b0, '0, EffNone, SlotFadeCount, 8'd9);
    push_event(ActTick, 1'b0, '0, EffNone, '0, '0);
    push_event(ActClear, 1'b0, '0, EffNone, '0, '0);
    // strobe, then disturb the level from outside
    push_event(ActLoad, 1'b0, '0, EffNone, SlotStrobeUpT, 8'd1);
    push_event(ActLoad, 1'b0, '0, EffNone, SlotStrobeUpV, LevelFull);
    push_event(ActStart, 1'b0, '0, EffStrobe, SlotBeyond, '0);
    push_event(ActTick, 1'b0, '0, EffNone, '0, '0);
    push_event(ActSetLevel, 1'b0, 8'd77, EffNone, '0, '0);
    push_event(ActTick, 1'b0, '0, EffNone, '0, '0);
    drain();

    run_phase(1'b1, 1'b0, 1'b0, 2'd0, 260, 33, 47, 0);
    run_phase(1'b1, 1'b1, 1'b0, 2'd1, 220, 33, 47, 0);
    run_phase(1'b0, 1'b1, 1'b1, 2'd0, 50, 47, 33, 0);
    // long receiver hold-off so the queue fills and input stalls
    run_phase(1'b1, 1'b0, 1'b1, 2'd3, 250, 47, 33, 300);
    run_phase(1'b1, 1'b1, 1'b1, DriveExtEffects, 110, 47, 33, 0);
    run_phase(1'b1, 1'b0, 1'b0, 2'd0, 240, 0, 0, 0);
    run_phase(1'b1, 1'b0, 1'b1, 2'd1, 180, 0, 0, 0);

    repeat (8) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/dim_pkg.sv
sv/dim_front.sv
sv/dim_queue.sv
sv/dim_back.sv
sv/led_dimmer_effect_engine.sv
dv/tb.sv
